// ----- src/imufps_pkg.sv -----
package imufps_pkg;

	// Frame framing bytes
	localparam logic [7:0] HDR_BYTE  = 8'h55;
	localparam logic [7:0] TYPE_BASE = 8'h51;

	// Frame position codes: hunting, type byte, data bytes 2..9, checksum
	localparam logic [3:0] POS_HUNT      = 4'd0;
	localparam logic [3:0] POS_TYPE      = 4'd1;
	localparam logic [3:0] POS_DATA0     = 4'd2;
	localparam logic [3:0] POS_AXIS_LAST = 4'd7;
	localparam logic [3:0] POS_CHECK     = 4'd10;

	// Widths
	localparam int GAIN_W  = 24;
	localparam int VALUE_W = 32;
	localparam int RAW_W   = 16;
	localparam int PROD_W  = RAW_W + GAIN_W + 1;

	typedef logic [1:0]         group_t;
	typedef logic [GAIN_W-1:0]  gain_t;
	typedef logic [1:0]         cfg_index_t;

	// Group codes
	localparam group_t GRP_ACCEL = 2'd0;
	localparam group_t GRP_RATE  = 2'd1;
	localparam group_t GRP_ANGLE = 2'd2;

	// Register indexes
	localparam cfg_index_t REG_ACCEL_GAIN = 2'd0;
	localparam cfg_index_t REG_RATE_GAIN  = 2'd1;
	localparam cfg_index_t REG_ANGLE_GAIN = 2'd2;

	// Gain reset values (factor times 2^24)
	localparam gain_t ACCEL_GAIN_RST = 24'd80282;
	localparam gain_t RATE_GAIN_RST  = 24'd1024000;
	localparam gain_t ANGLE_GAIN_RST = 24'd92160;

endpackage

// ----- src/imu_frame_parser_scaler_top.sv -----
// Channel   Direction  Signals                                      Handshake
// input     in         rx_byte                                      in_valid / in_ready
// result    out        group, value_x, value_y, value_z             out_valid / out_ready
// config    in         cfg_index, cfg_data                          cfg_wr_en, no wait
//
// One byte is taken per cycle while in_ready is high. A byte that completes a good frame
// has its frame registered by the parser in stage one, and the three 16 x 24 bit multiplies
// of stage two then load the output register once it is free.
// Reset clears the parser and the pipeline valids and loads the default gains.
// A stalled output holds the result; stage one can still fill behind it, and input is
// refused only while both stages hold a request.
module imu_frame_parser_scaler_top
	import imufps_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                rx_byte,
	output logic                      out_valid,
	input  logic                      out_ready,
	output group_t                    group,
	output logic signed [VALUE_W-1:0] value_x,
	output logic signed [VALUE_W-1:0] value_y,
	output logic signed [VALUE_W-1:0] value_z,
	input  logic                      cfg_wr_en,
	input  cfg_index_t                cfg_index,
	input  logic [GAIN_W-1:0]         cfg_data
);

	gain_t       accel_gain_q;
	gain_t       rate_gain_q;
	gain_t       angle_gain_q;

	logic [3:0]  pos_q;
	group_t      frame_group_q;
	logic [7:0]  sum_q;
	logic [7:0]  axis_q [6];

	logic        res_valid_s1;
	group_t      group_s1;
	gain_t       gain_s1;
	logic [7:0]  axis_s1 [6];

	logic        out_free;
	logic        move_s1;
	logic        accept;
	logic        is_type;
	logic        frame_good;
	logic [2:0]  axis_idx;
	gain_t       gain_sel;

	logic signed [PROD_W-1:0] prod_x;
	logic signed [PROD_W-1:0] prod_y;
	logic signed [PROD_W-1:0] prod_z;

	// Handshake: stage one empties into the output register when that is free.
	assign out_free = !out_valid || out_ready;
	assign move_s1  = res_valid_s1 && out_free;
	assign in_ready = !res_valid_s1 || out_free;
	assign accept   = in_valid && in_ready;

	// Frame decode helpers.
	assign is_type    = (rx_byte >= TYPE_BASE) && (rx_byte <= TYPE_BASE + 8'd2);
	assign frame_good = (pos_q == POS_CHECK) && (rx_byte == sum_q);
	assign axis_idx   = 3'(pos_q - POS_DATA0);

	// Gain of the finishing frame's group.
	always_comb begin
		case (frame_group_q)
			GRP_ACCEL: gain_sel = accel_gain_q;
			GRP_RATE:  gain_sel = rate_gain_q;
			default:   gain_sel = angle_gain_q;
		endcase
	end

	// Gain registers, written from the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_gain_q <= ACCEL_GAIN_RST;
			rate_gain_q  <= RATE_GAIN_RST;
			angle_gain_q <= ANGLE_GAIN_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ACCEL_GAIN: accel_gain_q <= cfg_data;
				REG_RATE_GAIN:  rate_gain_q  <= cfg_data;
				REG_ANGLE_GAIN: angle_gain_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	// Frame parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= POS_HUNT;
			frame_group_q <= GRP_ACCEL;
			sum_q         <= 8'd0;
		end else if (accept) begin
			if (pos_q == POS_HUNT || pos_q > POS_CHECK) begin
				if (rx_byte == HDR_BYTE) begin
					sum_q <= rx_byte;
					pos_q <= POS_TYPE;
				end else begin
					pos_q <= POS_HUNT;
				end
			end else if (pos_q == POS_TYPE) begin
				if (is_type) begin
					frame_group_q <= group_t'(rx_byte - TYPE_BASE);
					sum_q         <= sum_q + rx_byte;
					pos_q         <= POS_DATA0;
				end else if (rx_byte == HDR_BYTE) begin
					sum_q <= rx_byte;
					pos_q <= POS_TYPE;
				end else begin
					pos_q <= POS_HUNT;
				end
			end else if (pos_q < POS_CHECK) begin
				sum_q <= sum_q + rx_byte;
				pos_q <= pos_q + 4'd1;
			end else begin
				pos_q <= POS_HUNT;
			end
		end
	end

	// Axis bytes of the frame in progress; the last two data bytes are only summed.
	always_ff @(posedge clk) begin
		if (accept && pos_q >= POS_DATA0 && pos_q <= POS_AXIS_LAST) begin
			axis_q[axis_idx] <= rx_byte;
		end
	end

	// Stage one: a frame that passed its checksum waits here for the multipliers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else if (accept && frame_good) begin
			res_valid_s1 <= 1'b1;
		end else if (move_s1) begin
			res_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && frame_good) begin
			group_s1 <= frame_group_q;
			gain_s1  <= gain_sel;
			axis_s1  <= axis_q;
		end
	end

	// Stage two: signed word times unsigned gain, floored shift by eight.
	assign prod_x = $signed({axis_s1[1], axis_s1[0]}) * $signed({1'b0, gain_s1});
	assign prod_y = $signed({axis_s1[3], axis_s1[2]}) * $signed({1'b0, gain_s1});
	assign prod_z = $signed({axis_s1[5], axis_s1[4]}) * $signed({1'b0, gain_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (move_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			group   <= group_s1;
			value_x <= prod_x[VALUE_W+7:8];
			value_y <= prod_y[VALUE_W+7:8];
			value_z <= prod_z[VALUE_W+7:8];
		end
	end

endmodule
